/* rtl/core/ps2s2a_pkg.sv */
`default_nettype none

package ps2s2a_pkg;

  localparam logic [7:0] SC_LSHIFT   = 8'h12;
  localparam logic [7:0] SC_CAPS     = 8'h58;
  localparam logic [7:0] SC_RSHIFT   = 8'h59;
  localparam logic [7:0] SC_BREAK    = 8'hF0;
  localparam logic [7:0] SC_TABLE_N  = 8'h84;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5A;

  // Keyboard modifier and prefix flags carried from one byte to the next.
  typedef struct packed {
    logic shift;
    logic caps;
    logic brk;
  } flags_t;

  // Scancode set 2 make code to character. Codes past the table give zero.
  // F1-F12 map to 201-212.
  function automatic logic [7:0] key_map(input logic [7:0] code);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (code)
      8'h01: ch = 8'd209;
      8'h03: ch = 8'd205;
      8'h04: ch = 8'd203;
      8'h05: ch = 8'd201;
      8'h06: ch = 8'd202;
      8'h07: ch = 8'd212;
      8'h09: ch = 8'd210;
      8'h0A: ch = 8'd208;
      8'h0B: ch = 8'd206;
      8'h0C: ch = 8'd204;
      8'h0D: ch = 8'h09;
      8'h0E: ch = 8'h60;
      8'h15: ch = "q";
      8'h16: ch = "1";
      8'h1A: ch = "z";
      8'h1B: ch = "s";
      8'h1C: ch = "a";
      8'h1D: ch = "w";
      8'h1E: ch = "2";
      8'h21: ch = "c";
      8'h22: ch = "x";
      8'h23: ch = "d";
      8'h24: ch = "e";
      8'h25: ch = "4";
      8'h26: ch = "3";
      8'h29: ch = 8'h20;
      8'h2A: ch = "v";
      8'h2B: ch = "f";
      8'h2C: ch = "t";
      8'h2D: ch = "r";
      8'h2E: ch = "5";
      8'h31: ch = "n";
      8'h32: ch = "b";
      8'h33: ch = "h";
      8'h34: ch = "g";
      8'h35: ch = "y";
      8'h36: ch = "6";
      8'h3A: ch = "m";
      8'h3B: ch = "j";
      8'h3C: ch = "u";
      8'h3D: ch = "7";
      8'h3E: ch = "8";
      8'h41: ch = 8'h2C;
      8'h42: ch = "k";
      8'h43: ch = "i";
      8'h44: ch = "o";
      8'h45: ch = "0";
      8'h46: ch = "9";
      8'h49: ch = 8'h2E;
      8'h4A: ch = 8'h2F;
      8'h4B: ch = "l";
      8'h4C: ch = 8'h3B;
      8'h4D: ch = "p";
      8'h4E: ch = 8'h2D;
      8'h52: ch = 8'h27;
      8'h54: ch = 8'h5B;
      8'h55: ch = 8'h3D;
      8'h5A: ch = 8'h0A;
      8'h5B: ch = 8'h5D;
      8'h5D: ch = 8'h5C;
      8'h66: ch = 8'h08;
      8'h69: ch = "1";
      8'h6B: ch = "4";
      8'h6C: ch = "7";
      8'h70: ch = "0";
      8'h71: ch = 8'h2E;
      8'h72: ch = "2";
      8'h73: ch = "5";
      8'h74: ch = "6";
      8'h75: ch = "8";
      8'h76: ch = 8'h1B;
      8'h78: ch = 8'd211;
      8'h79: ch = 8'h2B;
      8'h7A: ch = "3";
      8'h7B: ch = 8'h2D;
      8'h7C: ch = 8'h2A;
      8'h7D: ch = "9";
      8'h83: ch = 8'd207;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ps2s2a_decode.sv */
`default_nettype none

// Combinational decode of one scancode byte against the current flags.
module ps2s2a_decode (
  input  wire logic [7:0]       scan_byte,
  input  ps2s2a_pkg::flags_t    flags,
  output ps2s2a_pkg::flags_t    flags_nxt,
  output logic                  emit,
  output logic [7:0]            char_code
);

  logic       is_shift;
  logic [7:0] raw_ch;
  logic       is_lower;

  assign is_shift = (scan_byte == ps2s2a_pkg::SC_LSHIFT) ||
                    (scan_byte == ps2s2a_pkg::SC_RSHIFT);
  assign raw_ch   = ps2s2a_pkg::key_map(scan_byte);
  assign is_lower = (raw_ch >= ps2s2a_pkg::CHAR_LO_A) && (raw_ch <= ps2s2a_pkg::CHAR_LO_Z);

  always_comb begin
    flags_nxt = flags;
    emit      = 1'b0;
    priority if (scan_byte == ps2s2a_pkg::SC_BREAK) begin
      flags_nxt.brk = 1'b1;
    end else if (flags.brk) begin
      flags_nxt.brk = 1'b0;
      if (is_shift) begin
        flags_nxt.shift = 1'b0;
      end
    end else if (is_shift) begin
      flags_nxt.shift = 1'b1;
    end else if (scan_byte == ps2s2a_pkg::SC_CAPS) begin
      flags_nxt.caps = ~flags.caps;
    end else begin
      emit = 1'b1;
    end
  end

  // The table already returns zero for codes at or past its end.
  assign char_code = ((flags.shift || flags.caps) && is_lower) ?
                     (raw_ch - ps2s2a_pkg::CASE_OFFSET) : raw_ch;

endmodule

`default_nettype wire

/* rtl/core/ps2_set2_scancode_to_ascii.sv */
`default_nettype none

// PS/2 scancode set 2 to ASCII decoder. Each input transaction carries one raw
// keyboard byte; the block tracks shift, caps lock and a pending break prefix.
// Make codes of ordinary keys produce one output transaction with the character
// (F1-F12 come out as 201-212, unmapped codes as zero), uppercased for a-z while
// shift or caps lock is active, together with the shift and caps flags. The
// break prefix F0h, the byte that follows it, shift makes and the caps lock make
// produce no output transaction. Extended E0h codes are not interpreted. The
// block is two registers deep: an input register holds the byte, the table
// lookup and flag update sit between it and the output register. It accepts
// one byte every clock cycle while no stall holds it back: a stalled output
// register with an undelivered result keeps a byte that would produce a further
// result in the input register, and no new byte is accepted until it moves on.
module ps2_set2_scancode_to_ascii (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_scan_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char_code,
  output logic            out_shift_active,
  output logic            out_caps_active
);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Keyboard flags, updated when the byte in the input register is consumed.
  ps2s2a_pkg::flags_t flags_r;
  ps2s2a_pkg::flags_t flags_nxt;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_shift_r;
  logic       out_caps_r;

  logic       emit;
  logic [7:0] char_code;
  logic       out_free;
  logic       s1_adv;

  ps2s2a_decode u_decode (
    .scan_byte (s1_byte_r),
    .flags     (flags_r),
    .flags_nxt (flags_nxt),
    .emit      (emit),
    .char_code (char_code)
  );

  // A byte that produces nothing leaves the input register at once; one that
  // produces a result waits for the output register to be free or draining.
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        flags_r <= flags_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_adv && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_scan_byte;
    end
    if (s1_adv && emit) begin
      out_char_r  <= char_code;
      out_shift_r <= flags_nxt.shift;
      out_caps_r  <= flags_nxt.caps;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_code    = out_char_r;
  assign out_shift_active = out_shift_r;
  assign out_caps_active  = out_caps_r;

  // A consumed break prefix must leave the break flag armed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_byte_r == ps2s2a_pkg::SC_BREAK)) |=> flags_r.brk)
    else $error("break prefix did not arm the break flag");

  // The byte after a break prefix never yields a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && flags_r.brk) |-> !emit)
    else $error("break code produced a result");

  // An uppercase letter only appears while shift or caps lock is active.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_char_code >= ps2s2a_pkg::CHAR_UP_A) &&
     (out_char_code <= ps2s2a_pkg::CHAR_UP_Z)) |-> (out_shift_active || out_caps_active))
    else $error("uppercase letter without shift or caps lock");

  // With both registers empty the block must take a new transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r && !out_valid_r) |-> in_ready)
    else $error("idle block refused a transaction");

endmodule

`default_nettype wire

/* sim/ps2_set2_scancode_to_ascii_test.sv */
`default_nettype none

// One character the decoder should deliver, with the modifier flags that go with it.
typedef struct packed {
  logic [7:0] char_code;
  logic       shift_active;
  logic       caps_active;
} keystroke_t;

// Tracks the keyboard state and the characters that are still owed by the decoder.
class keystroke_scoreboard;
  logic         shift_held;
  logic         caps_on;
  logic         break_pending;
  keystroke_t   owed_chars[$];
  int unsigned  mismatches;

  // Scancode set 2 make code to character, entries 00h-83h.
  logic [7:0] char_table [132] = '{
    8'h00, 8'hD1, 8'h00, 8'hCD, 8'hCB, 8'hC9, 8'hCA, 8'hD4,
    8'h00, 8'hD2, 8'hD0, 8'hCE, 8'hCC, 8'h09, 8'h60, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h71, 8'h31, 8'h00,
    8'h00, 8'h00, 8'h7A, 8'h73, 8'h61, 8'h77, 8'h32, 8'h00,
    8'h00, 8'h63, 8'h78, 8'h64, 8'h65, 8'h34, 8'h33, 8'h00,
    8'h00, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h35, 8'h00,
    8'h00, 8'h6E, 8'h62, 8'h68, 8'h67, 8'h79, 8'h36, 8'h00,
    8'h00, 8'h00, 8'h6D, 8'h6A, 8'h75, 8'h37, 8'h38, 8'h00,
    8'h00, 8'h2C, 8'h6B, 8'h69, 8'h6F, 8'h30, 8'h39, 8'h00,
    8'h00, 8'h2E, 8'h2F, 8'h6C, 8'h3B, 8'h70, 8'h2D, 8'h00,
    8'h00, 8'h00, 8'h27, 8'h00, 8'h5B, 8'h3D, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h0A, 8'h5D, 8'h00, 8'h5C, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
    8'h00, 8'h31, 8'h00, 8'h34, 8'h37, 8'h00, 8'h00, 8'h00,
    8'h30, 8'h2E, 8'h32, 8'h35, 8'h36, 8'h38, 8'h1B, 8'h00,
    8'hD3, 8'h2B, 8'h33, 8'h2D, 8'h2A, 8'h39, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'hCF
  };

  function new();
    shift_held    = 1'b0;
    caps_on       = 1'b0;
    break_pending = 1'b0;
    mismatches    = 0;
  endfunction

  // Advances the keyboard state by one accepted byte and queues any character it makes.
  function void note_scan_byte(logic [7:0] code);
    keystroke_t ks;
    if (code == ps2s2a_pkg::SC_BREAK) begin
      break_pending = 1'b1;
    end else if (break_pending) begin
      break_pending = 1'b0;
      if (code == ps2s2a_pkg::SC_LSHIFT || code == ps2s2a_pkg::SC_RSHIFT) shift_held = 1'b0;
    end else if (code == ps2s2a_pkg::SC_LSHIFT || code == ps2s2a_pkg::SC_RSHIFT) begin
      shift_held = 1'b1;
    end else if (code == ps2s2a_pkg::SC_CAPS) begin
      caps_on = !caps_on;
    end else begin
      ks.char_code = (code < ps2s2a_pkg::SC_TABLE_N) ? char_table[code] : 8'h00;
      if ((shift_held || caps_on) &&
          ks.char_code >= ps2s2a_pkg::CHAR_LO_A && ks.char_code <= ps2s2a_pkg::CHAR_LO_Z)
        ks.char_code = ks.char_code - ps2s2a_pkg::CASE_OFFSET;
      ks.shift_active = shift_held;
      ks.caps_active  = caps_on;
      owed_chars.push_back(ks);
    end
  endfunction

  function void check_char(keystroke_t got);
    keystroke_t want;
    if (owed_chars.size() == 0) begin
      $error("output transaction with nothing expected: char_code %0h", got.char_code);
      mismatches++;
      return;
    end
    want = owed_chars.pop_front();
    if (got.char_code !== want.char_code) begin
      $error("char_code: expected %0h, got %0h", want.char_code, got.char_code);
      mismatches++;
    end
    if (got.shift_active !== want.shift_active) begin
      $error("shift_active: expected %0b, got %0b", want.shift_active, got.shift_active);
      mismatches++;
    end
    if (got.caps_active !== want.caps_active) begin
      $error("caps_active: expected %0b, got %0b", want.caps_active, got.caps_active);
      mismatches++;
    end
  endfunction
endclass

module ps2_set2_scancode_to_ascii_test;

  // Number of consecutive cycles without any transaction before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;
  // Roughly how many bytes the random part of the run sends.
  localparam int unsigned RANDOM_BYTES = 1000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_scan_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char_code;
  logic       out_shift_active;
  logic       out_caps_active;

  keystroke_scoreboard board;

  // Bytes left in the sender's current burst; a gap is inserted when it runs out.
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  // Opening sequence: table extremes, every modifier path, the double break prefix,
  // a caps-lock break that must not toggle caps, and codes past the end of the table.
  logic [7:0] opening_bytes [25] = '{
    8'h00, 8'h1C, ps2s2a_pkg::SC_LSHIFT, 8'h1C, 8'h16, ps2s2a_pkg::SC_BREAK,
    ps2s2a_pkg::SC_LSHIFT, ps2s2a_pkg::SC_CAPS, 8'h15, ps2s2a_pkg::SC_RSHIFT, 8'h1A,
    ps2s2a_pkg::SC_BREAK, ps2s2a_pkg::SC_RSHIFT, ps2s2a_pkg::SC_BREAK,
    ps2s2a_pkg::SC_CAPS, 8'h24, ps2s2a_pkg::SC_CAPS, ps2s2a_pkg::SC_BREAK,
    ps2s2a_pkg::SC_BREAK, 8'h1D, 8'h83, ps2s2a_pkg::SC_TABLE_N, 8'hFF, 8'h05, 8'h02
  };

  ps2_set2_scancode_to_ascii DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_scan_byte     (in_scan_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_code    (out_char_code),
    .out_shift_active (out_shift_active),
    .out_caps_active  (out_caps_active)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Presents one byte and returns at the clock edge where the transaction completes.
  // Called on a rising edge. When the current burst is used up, valid drops for a
  // random gap first; otherwise valid stays high straight into the next byte.
  task automatic send_byte(input logic [7:0] code);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      // Mostly short bursts, with an occasional long stretch of back-to-back bytes.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_scan_byte <= code;
    do @(posedge clk); while (!in_ready);
    board.note_scan_byte(code);
  endtask

  // A press followed by its release, the shape most of the random traffic takes.
  task automatic tap_key(input logic [7:0] code);
    send_byte(code);
    send_byte(ps2s2a_pkg::SC_BREAK);
    send_byte(code);
  endtask

  // Receiver back-pressure: the pattern is redrawn periodically from always ready,
  // coin flips, periodic ready pulses, and long stalls with rare ready pulses.
  initial begin : receiver_stalls
    int unsigned cyc;
    int unsigned pattern;
    cyc = 0;
    pattern = 0;
    forever begin
      @(posedge clk);
      if (cyc % 64 == 0) pattern = $urandom_range(0, 3);
      case (pattern)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) != 0);
        2: out_ready <= (cyc % 4 == 0);
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
      cyc++;
    end
  end

  // Output checking and the hang watchdog. Both sample the handshake at the rising
  // edge, before any of this edge's updates take effect.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_char('{out_char_code, out_shift_active, out_caps_active});
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= HANG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned pick;
    logic [7:0] code;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    // Random typing. Most traffic is well-formed press/release pairs with shift held
    // around some of them; the rest is caps toggles, bare presses and raw noise,
    // which also produces stray break prefixes and codes past the table.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      code = 8'($urandom_range(0, ps2s2a_pkg::SC_TABLE_N - 1));
      if (pick < 45) begin
        tap_key(code);
        sent += 3;
      end else if (pick < 60) begin
        send_byte(($urandom_range(0, 1) != 0) ? ps2s2a_pkg::SC_LSHIFT : ps2s2a_pkg::SC_RSHIFT);
        tap_key(code);
        send_byte(ps2s2a_pkg::SC_BREAK);
        send_byte(($urandom_range(0, 1) != 0) ? ps2s2a_pkg::SC_LSHIFT : ps2s2a_pkg::SC_RSHIFT);
        sent += 6;
      end else if (pick < 68) begin
        tap_key(ps2s2a_pkg::SC_CAPS);
        sent += 3;
      end else if (pick < 80) begin
        // A held key that repeats without a release in between.
        send_byte(code);
        sent += 1;
      end else if (pick < 88) begin
        send_byte(8'($urandom_range(ps2s2a_pkg::SC_TABLE_N, 8'hFF)));
        sent += 1;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent += 1;
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed character, then keep clocking the two-stage pipeline
    // so that any extra output transaction still gets caught.
    while (board.owed_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* ps2_set2_scancode_to_ascii.f */
rtl/core/ps2s2a_pkg.sv
rtl/core/ps2s2a_decode.sv
rtl/core/ps2_set2_scancode_to_ascii.sv
sim/ps2_set2_scancode_to_ascii_test.sv
